// ===== rtl/core/fece_pkg.sv =====
// Shared types, constants and the palette function of the fire effect cell engine.
package fece_pkg;

   localparam int MAX_COLS_DEF = 32;
   localparam int MAX_ROWS_DEF = 32;

   localparam int DIM_W       = 6;   // width of the cols/rows registers
   localparam int POS_W       = 6;   // row/col field width, covers matrices up to 64
   localparam int LED_W       = 10;
   localparam int HEAT_W      = 8;
   localparam int NIB_W       = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [DIM_W-1:0]     DIM_RESET = 6'd16;
   localparam logic [DIM_W-1:0]     DIM_MIN   = 6'd2;
   localparam logic [NIB_W-1:0]     HOT_LIMIT = 4'd9;
   localparam logic [HEAT_W-1:0]    HEAT_HOT  = 8'd255;

   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS  = 2'd1;

   // One classified item as it travels from the front to the back.
   typedef struct packed {
      logic              seed;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic              first;
      logic              last;
      logic              fend;
      logic [LED_W-1:0]  led;
      logic [NIB_W-1:0]  nibble;
   } fece_entry_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } fece_rgb_type;

   // Eight ramps of 32 steps each.
   function automatic fece_rgb_type fece_palette(input logic [HEAT_W-1:0] h);
      fece_rgb_type c;
      logic [4:0]   i;
      i = h[4:0];
      c.red   = 8'd0;
      c.green = 8'd0;
      c.blue  = 8'd0;
      unique case (h[7:5])
         3'd0: begin
            c.blue = {2'b00, i, 1'b0};
         end
         3'd1: begin
            c.red  = {i, 3'b000};
            c.blue = 8'd64 - {2'b00, i, 1'b0};
         end
         3'd2: begin
            c.red   = 8'd255;
            c.green = {i, 3'b000};
         end
         3'd3: begin
            c.red   = 8'd255;
            c.green = 8'd255;
            c.blue  = {1'b0, i, 2'b00};
         end
         3'd4: begin
            c.red   = 8'd255;
            c.green = 8'd255;
            c.blue  = 8'd64 + {1'b0, i, 2'b00};
         end
         3'd5: begin
            c.red   = 8'd255;
            c.green = 8'd255;
            c.blue  = 8'd128 + {1'b0, i, 2'b00};
         end
         3'd6: begin
            c.red   = 8'd255;
            c.green = 8'd255;
            c.blue  = 8'd192 + {3'b000, i};
         end
         default: begin
            c.red   = 8'd255;
            c.green = 8'd255;
            c.blue  = 8'd224 + {3'b000, i};
         end
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/core/fece_queue.sv =====
// Short item queue between the front and the back of the fire effect engine.
module fece_queue import fece_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  fece_entry_type push_entry,
   output logic           ready,
   input  logic           pop,
   output fece_entry_type head,
   output logic           valid
);

   fece_entry_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/fece_front.sv =====
// Front of the fire effect engine: size registers, cell cursor and item classification.
module fece_front import fece_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [NIB_W-1:0]     req_rand_value,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data,
   input  logic                 q_ready,
   input  logic                 clearing,
   output logic                 q_push,
   output fece_entry_type       q_entry
);

   localparam int CW = $clog2(MAX_COLS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam logic [DIM_W-1:0] COLS_RST =
      (MAX_COLS < 16) ? DIM_W'(MAX_COLS) : DIM_RESET;
   localparam logic [DIM_W-1:0] ROWS_RST =
      (MAX_ROWS < 16) ? DIM_W'(MAX_ROWS) : DIM_RESET;

   logic [DIM_W-1:0] cols_ff, cols_in;
   logic [DIM_W-1:0] rows_ff, rows_in;
   logic             seed_ff, seed_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;

   logic [DIM_W-1:0] clamp_cols;
   logic [DIM_W-1:0] clamp_rows;
   logic             row_end;
   logic [12:0]      led_full;
   logic             restart;

   assign req_stall = !q_ready || clearing;
   assign q_push    = req_valid && !req_stall;

   always_comb begin
      if (csr_data < DIM_MIN) begin
         clamp_cols = DIM_MIN;
      end else if ({1'b0, csr_data} > (DIM_W+1)'(MAX_COLS)) begin
         clamp_cols = DIM_W'(MAX_COLS);
      end else begin
         clamp_cols = csr_data;
      end
      if (csr_data < DIM_MIN) begin
         clamp_rows = DIM_MIN;
      end else if ({1'b0, csr_data} > (DIM_W+1)'(MAX_ROWS)) begin
         clamp_rows = DIM_W'(MAX_ROWS);
      end else begin
         clamp_rows = csr_data;
      end
   end

   // Classify the item at the cursor.
   always_comb begin
      row_end  = ((DIM_W+1)'(col_ff) + (DIM_W+1)'(1)) >= {1'b0, cols_ff};
      led_full = (13'(row_ff) + 13'd1) * 13'(cols_ff) + 13'(col_ff);

      q_entry.seed   = seed_ff;
      q_entry.row    = seed_ff ? POS_W'(rows_ff - DIM_W'(1)) : POS_W'(row_ff);
      q_entry.col    = POS_W'(col_ff);
      q_entry.first  = (col_ff == '0);
      q_entry.last   = row_end;
      q_entry.fend   = !seed_ff && row_end && (row_ff == '0);
      q_entry.led    = led_full[LED_W-1:0];
      q_entry.nibble = req_rand_value;
   end

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      seed_in = seed_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      restart = 1'b0;
      if (csr_write && (csr_index == CSR_COLS)) begin
         cols_in = clamp_cols;
         restart = 1'b1;
      end else if (csr_write && (csr_index == CSR_ROWS)) begin
         rows_in = clamp_rows;
         restart = 1'b1;
      end
      if (restart) begin
         seed_in = 1'b1;
         row_in  = '0;
         col_in  = '0;
      end else if (q_push) begin
         if (!row_end) begin
            col_in = col_ff + CW'(1);
         end else if (seed_ff) begin
            seed_in = 1'b0;
            row_in  = RW'(rows_ff - DIM_W'(2));
            col_in  = '0;
         end else if (row_ff == '0) begin
            seed_in = 1'b1;
            col_in  = '0;
         end else begin
            row_in = row_ff - RW'(1);
            col_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RST;
         rows_ff <= ROWS_RST;
         seed_ff <= 1'b1;
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         seed_ff <= seed_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

endmodule

// ===== rtl/core/fece_back.sv =====
// Back of the fire effect engine: heat store, read sequencer, divide pipeline, output register.
module fece_back import fece_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  fece_entry_type    q_head,
   output logic              q_pop,
   output logic              clearing,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [LED_W-1:0]  rsp_led_index,
   output logic [HEAT_W-1:0] rsp_heat,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic              rsp_frame_end
);

   localparam int CW     = $clog2(MAX_COLS);
   localparam int RW     = $clog2(MAX_ROWS);
   localparam int AW     = RW + CW;
   localparam int DEPTH  = 1 << AW;
   localparam int SUM_W  = 10;
   localparam int NUM_W  = 17;
   localparam int MUL_W  = 18;
   localparam int PROD_W = NUM_W + MUL_W;

   // floor(n/505) = (n*M_INT) >> SH_INT and floor(n/15) = (n*M_EDGE) >> SH_EDGE,
   // exact over the numerator ranges that reach here.
   localparam logic [MUL_W-1:0] M_INT   = 18'd132889;
   localparam logic [MUL_W-1:0] M_EDGE  = 18'd4370;
   localparam int               SH_INT  = 26;
   localparam int               SH_EDGE = 16;

   typedef enum logic [2:0] {
      OP_MID       = 3'd0,
      OP_RIGHT     = 3'd1,
      OP_SHIFT     = 3'd2,
      OP_OWN_SHIFT = 3'd3,
      OP_OWN       = 3'd4
   } rd_op_type;

   logic [HEAT_W-1:0] heat_mem [DEPTH];

   logic              clr_ff;
   logic [AW-1:0]     clr_addr_ff;

   logic [1:0]        step_ff, step_in;

   logic              s1_valid_ff;
   rd_op_type         s1_op_ff;
   fece_entry_type    s1_item_ff;
   logic [HEAT_W-1:0] rd_data_ff;

   logic [HEAT_W-1:0] win_l_ff, win_m_ff, win_r_ff, own_ff;

   logic              s2_valid_ff;
   fece_entry_type    s2_item_ff;

   logic              s3_valid_ff;
   fece_entry_type    s3_item_ff;
   logic [NUM_W-1:0]  s3_num_ff;
   logic              s3_int_ff, s3_small_ff, s3_smallv_ff;

   logic              s4_valid_ff;
   fece_entry_type    s4_item_ff;
   logic [PROD_W-1:0] s4_prod_ff;
   logic              s4_int_ff, s4_small_ff, s4_smallv_ff;

   logic              rsp_valid_ff;
   logic [LED_W-1:0]  rsp_led_ff;
   logic [HEAT_W-1:0] rsp_heat_ff;
   logic [7:0]        rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic              rsp_fend_ff;

   logic              adv, pipe_empty, go, hold, last_step, rd_en;
   rd_op_type         op;
   logic [RW-1:0]     row_c, row_up;
   logic [CW-1:0]     col_c, col_rt;
   logic [AW-1:0]     rd_addr;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [HEAT_W-1:0] wr_data;

   logic [SUM_W-1:0]  sum_c;
   logic              edge_c;
   logic [NUM_W-1:0]  num_c;
   logic [PROD_W-1:0] prod_c;
   logic [8:0]        quo_c;
   logic [HEAT_W-1:0] heat_c;
   fece_rgb_type      rgb_c;

   assign clearing   = clr_ff;
   assign adv        = !s4_valid_ff || !rsp_valid_ff || !rsp_stall;
   assign pipe_empty = !s1_valid_ff && !s2_valid_ff && !s3_valid_ff && !s4_valid_ff;

   // Read sequencer: one store read per cycle unless clearing, held or frozen by rsp_stall.
   always_comb begin
      row_c     = q_head.row[RW-1:0];
      col_c     = q_head.col[CW-1:0];
      row_up    = row_c + RW'(1);
      col_rt    = col_c + CW'(1);
      op        = OP_OWN;
      rd_addr   = {row_c, col_c};
      last_step = 1'b1;
      priority if (q_head.seed) begin
         last_step = 1'b1;
      end else if (q_head.first) begin
         unique case (step_ff)
            2'd0: begin
               op        = OP_MID;
               rd_addr   = {row_up, CW'(0)};
               last_step = 1'b0;
            end
            2'd1: begin
               op        = OP_RIGHT;
               rd_addr   = {row_up, CW'(1)};
               last_step = 1'b0;
            end
            default: begin
               op = OP_OWN;
            end
         endcase
      end else if (q_head.last) begin
         op = OP_OWN_SHIFT;
      end else if (step_ff == 2'd0) begin
         op        = OP_SHIFT;
         rd_addr   = {row_up, col_rt};
         last_step = 1'b0;
      end else begin
         op = OP_OWN;
      end
      // a row start or a seed waits for all pending writes to land
      hold    = (step_ff == 2'd0) && (q_head.seed || q_head.first) && !pipe_empty;
      go      = q_valid && !clr_ff && adv && !hold;
      q_pop   = go && last_step;
      rd_en   = go && !q_head.seed;
      step_in = step_ff;
      if (go) begin
         step_in = last_step ? 2'd0 : step_ff + 2'd1;
      end
   end

   // Sum and numerator.
   always_comb begin
      edge_c = s2_item_ff.first || s2_item_ff.last;
      priority if (s2_item_ff.first) begin
         sum_c = SUM_W'(win_m_ff) + SUM_W'(win_r_ff) + SUM_W'(own_ff);
      end else if (s2_item_ff.last) begin
         sum_c = SUM_W'(win_l_ff) + SUM_W'(win_m_ff) + SUM_W'(own_ff);
      end else begin
         sum_c = SUM_W'(win_l_ff) + SUM_W'(win_m_ff) + SUM_W'(win_r_ff) + SUM_W'(own_ff);
      end
      if (edge_c) begin
         num_c = NUM_W'(sum_c) * NUM_W'(5) - NUM_W'(18);
      end else begin
         num_c = NUM_W'(sum_c) * NUM_W'(125) - NUM_W'(606);
      end
   end

   assign prod_c = PROD_W'(s3_num_ff) * PROD_W'(s3_int_ff ? M_INT : M_EDGE);

   always_comb begin
      quo_c = s4_int_ff ? s4_prod_ff[SH_INT +: 9] : s4_prod_ff[SH_EDGE +: 9];
      if (s4_small_ff) begin
         heat_c = {7'd0, s4_smallv_ff};
      end else if (quo_c[8]) begin
         heat_c = HEAT_HOT;
      end else begin
         heat_c = quo_c[7:0];
      end
      rgb_c = fece_palette(heat_c);
   end

   // Single write port: clearing pass, finished cells, seeds.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_data = '0;
      priority if (clr_ff) begin
         wr_en = 1'b1;
      end else if (s4_valid_ff && adv) begin
         wr_en   = 1'b1;
         wr_addr = {s4_item_ff.row[RW-1:0], s4_item_ff.col[CW-1:0]};
         wr_data = heat_c;
      end else if (go && q_head.seed) begin
         wr_en   = 1'b1;
         wr_addr = {row_c, col_c};
         wr_data = (q_head.nibble >= HOT_LIMIT) ? HEAT_HOT : '0;
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heat_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= heat_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         step_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == {AW{1'b1}}) begin
               clr_ff <= 1'b0;
            end
         end
         step_ff <= step_in;
         if (adv) begin
            s1_valid_ff <= rd_en;
            s2_valid_ff <= s1_valid_ff && ((s1_op_ff == OP_OWN) || (s1_op_ff == OP_OWN_SHIFT));
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
         end
         if (s4_valid_ff && adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_op_ff   <= op;
         s1_item_ff <= q_head;
      end
      if (adv && s1_valid_ff) begin
         unique case (s1_op_ff)
            OP_MID: begin
               win_m_ff <= rd_data_ff;
            end
            OP_RIGHT: begin
               win_r_ff <= rd_data_ff;
            end
            OP_SHIFT: begin
               win_l_ff <= win_m_ff;
               win_m_ff <= win_r_ff;
               win_r_ff <= rd_data_ff;
            end
            OP_OWN_SHIFT: begin
               win_l_ff <= win_m_ff;
               win_m_ff <= win_r_ff;
               own_ff   <= rd_data_ff;
            end
            default: begin
               own_ff <= rd_data_ff;
            end
         endcase
         s2_item_ff <= s1_item_ff;
      end
      if (adv && s2_valid_ff) begin
         s3_item_ff   <= s2_item_ff;
         s3_num_ff    <= num_c;
         s3_int_ff    <= !edge_c;
         s3_small_ff  <= edge_c ? (sum_c <= SUM_W'(3)) : (sum_c <= SUM_W'(4));
         s3_smallv_ff <= edge_c && (sum_c == SUM_W'(3));
      end
      if (adv && s3_valid_ff) begin
         s4_item_ff   <= s3_item_ff;
         s4_prod_ff   <= prod_c;
         s4_int_ff    <= s3_int_ff;
         s4_small_ff  <= s3_small_ff;
         s4_smallv_ff <= s3_smallv_ff;
      end
      if (adv && s4_valid_ff) begin
         rsp_led_ff   <= s4_item_ff.led;
         rsp_heat_ff  <= heat_c;
         rsp_red_ff   <= rgb_c.red;
         rsp_green_ff <= rgb_c.green;
         rsp_blue_ff  <= rgb_c.blue;
         rsp_fend_ff  <= s4_item_ff.fend;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_index = rsp_led_ff;
   assign rsp_heat      = rsp_heat_ff;
   assign rsp_red       = rsp_red_ff;
   assign rsp_green     = rsp_green_ff;
   assign rsp_blue      = rsp_blue_ff;
   assign rsp_frame_end = rsp_fend_ff;

endmodule

// ===== rtl/core/fire_effect_cell_engine.sv =====
// Top level of the fire effect cell engine: front, item queue and back.
//
//  Channel  Dir  Handshake              Payload
//  req      in   req_valid / req_stall  req_rand_value
//  rsp      out  rsp_valid / rsp_stall  rsp_led_index, rsp_heat, rsp_red, rsp_green,
//                                       rsp_blue, rsp_frame_end
//  csr      in   csr_write              csr_index, csr_data
//
// Sequencing: a seed item only writes the store; an update item reads row+1 at its
// column+1, then its own cell, in an interior column, only its own cell in the last
// column, and row+1 at columns 0 and 1, then its own cell, in column 0. Column 0 and
// the first seed of a frame wait while the previous row's writes land. The single
// read port of the heat store sets this.
// Reset is synchronous; afterwards a clearing pass zeroes the heat store, one entry
// a cycle, all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries (1024 by default), with
// req_stall held high.
// A 4-entry queue splits front and back; the back freezes only while rsp holds an
// item under rsp_stall.
module fire_effect_cell_engine import fece_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [NIB_W-1:0]     req_rand_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [LED_W-1:0]     rsp_led_index,
   output logic [HEAT_W-1:0]    rsp_heat,
   output logic [7:0]           rsp_red,
   output logic [7:0]           rsp_green,
   output logic [7:0]           rsp_blue,
   output logic                 rsp_frame_end,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   logic           q_push, q_ready, q_pop, q_valid;
   logic           clearing;
   fece_entry_type q_entry, q_head;

   // Classify each accepted item from the cell cursor.
   fece_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rand_value (req_rand_value),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .q_ready        (q_ready),
      .clearing       (clearing),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   // Hold classified items until the back is free.
   fece_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .ready      (q_ready),
      .pop        (q_pop),
      .head       (q_head),
      .valid      (q_valid)
   );

   // Read neighbors, divide, write back and emit the colored cell.
   fece_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_led_index (rsp_led_index),
      .rsp_heat      (rsp_heat),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_frame_end (rsp_frame_end)
   );

   // No item enters while the heat store is being cleared.
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_stall)
      else $error("item accepted during clearing pass");

   // The front never pushes into a full queue.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_ready)
      else $error("push into full queue");

   // The back never pops an empty queue.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   // No result in the cycle after a reset cycle.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

endmodule

// ===== dv/tb_fire_effect_cell_engine.sv =====
// Self-checking testbench for the fire effect cell engine: heat predictor, drivers and checks.
module tb_fire_effect_cell_engine import fece_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF         = 10;
   localparam int RESET_CYCLES     = 7;
   localparam int SETTLE_CYCLES    = 40;     // well past the block's latency plus trailing seed items
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int RANDOM_ITEMS     = 380;
   localparam int TAIL_ITEMS       = 60;     // no idling at all on the last stretch
   localparam int CYCLE_LIMIT      = 200000;

   // Indexes with no register behind them; writes there must be dropped.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [LED_W-1:0]  led_index;
      logic [HEAT_W-1:0] heat;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic              frame_end;
   } pixel_type;

   // Mirror of the heat map and cursor, plus the queue of pixels still owed by the block.
   class fire_cell_scoreboard;
      bit [HEAT_W-1:0] heat_map [MAX_ROWS_DEF][MAX_COLS_DEF];
      bit              seeding;
      int unsigned     row_pos;
      int unsigned     col_pos;
      int unsigned     n_cols;
      int unsigned     n_rows;
      pixel_type       expected_pixels [$];
      int unsigned     mismatches;

      function new();
         n_cols     = 32'(DIM_RESET);
         n_rows     = 32'(DIM_RESET);
         mismatches = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         seeding = 1'b1;
         row_pos = 0;
         col_pos = 0;
      endfunction

      function int unsigned clamp_dim(bit [DIM_W-1:0] d, int unsigned top);
         if (d < DIM_MIN) return 32'(DIM_MIN);
         if (32'(d) > top) return top;
         return 32'(d);
      endfunction

      // Any write to a real register restarts the frame; the heat map is kept.
      function void write_reg(bit [CSR_IDX_W-1:0] idx, bit [DIM_W-1:0] d);
         if (idx == CSR_COLS) begin
            n_cols = clamp_dim(d, MAX_COLS_DEF);
            restart_frame();
         end else if (idx == CSR_ROWS) begin
            n_rows = clamp_dim(d, MAX_ROWS_DEF);
            restart_frame();
         end
      endfunction

      // Eight ramps of 32 steps: blue, red rising, green rising, then blue climbing to white.
      function bit [23:0] ramp_color(bit [HEAT_W-1:0] h);
         int unsigned i;
         int unsigned k;
         bit [7:0]    rd;
         bit [7:0]    gr;
         bit [7:0]    bl;
         i  = 32'(h[4:0]);
         k  = 32'(h[7:5]);
         rd = 8'd255;
         gr = 8'd255;
         bl = 8'd0;
         case (k)
            0: begin
               rd = 8'd0;
               gr = 8'd0;
               bl = 8'(2 * i);
            end
            1: begin
               rd = 8'(8 * i);
               gr = 8'd0;
               bl = 8'(64 - 2 * i);
            end
            2: begin
               gr = 8'(8 * i);
            end
            3, 4, 5: begin
               bl = 8'(64 * (k - 3) + 4 * i);
            end
            6: begin
               bl = 8'(192 + i);
            end
            default: begin
               bl = 8'(224 + i);
            end
         endcase
         return {rd, gr, bl};
      endfunction

      // Advance the fire by one cell and queue the pixel it produces, if any.
      function void note_step(bit [NIB_W-1:0] nibble);
         int unsigned r;
         int unsigned c;
         int unsigned total;
         int unsigned v;
         pixel_type   px;
         r = row_pos;
         c = col_pos;
         if (seeding) begin
            heat_map[n_rows - 1][c] = (nibble >= HOT_LIMIT) ? HEAT_HOT : 8'd0;
            if (c + 1 >= n_cols) begin
               seeding = 1'b0;
               row_pos = n_rows - 2;
               col_pos = 0;
            end else begin
               col_pos = c + 1;
            end
            return;
         end
         total = 32'(heat_map[r + 1][c]);
         total = total + 32'(heat_map[r][c]);
         if (c == 0) begin
            total = total + 32'(heat_map[r + 1][1]);
         end else if (c == n_cols - 1) begin
            total = total + 32'(heat_map[r + 1][c - 1]);
         end else begin
            total = total + 32'(heat_map[r + 1][c - 1]);
            total = total + 32'(heat_map[r + 1][c + 1]);
         end
         // Edge: S/3 - 1.2 above 1; interior: S/4.04 - 1.2 above 1; exact rationals.
         if (c == 0 || c == n_cols - 1)
            v = (total > 3) ? (5 * total - 18) / 15 : total / 3;
         else
            v = (25 * total > 101) ? (125 * total - 606) / 505 : 0;
         if (v > 255) v = 255;
         heat_map[r][c] = v[7:0];
         px.led_index = LED_W'((r + 1) * n_cols + c);
         px.heat      = v[7:0];
         {px.red, px.green, px.blue} = ramp_color(v[7:0]);
         px.frame_end = 1'b0;
         if (c + 1 >= n_cols) begin
            col_pos = 0;
            if (r == 0) begin
               px.frame_end = 1'b1;
               restart_frame();
            end else begin
               row_pos = r - 1;
            end
         end else begin
            col_pos = c + 1;
         end
         expected_pixels.push_back(px);
      endfunction

      function void compare_field(string field, logic [LED_W-1:0] want, logic [LED_W-1:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected pixel, expected none, actual led %0d heat %0d",
                     $time, got.led_index, got.heat);
            return;
         end
         want = expected_pixels.pop_front();
         compare_field("led_index", want.led_index, got.led_index);
         compare_field("heat", LED_W'(want.heat), LED_W'(got.heat));
         compare_field("red", LED_W'(want.red), LED_W'(got.red));
         compare_field("green", LED_W'(want.green), LED_W'(got.green));
         compare_field("blue", LED_W'(want.blue), LED_W'(got.blue));
         compare_field("frame_end", LED_W'(want.frame_end), LED_W'(got.frame_end));
      endfunction
   endclass

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [NIB_W-1:0]     req_rand_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [LED_W-1:0]     rsp_led_index;
   logic [HEAT_W-1:0]    rsp_heat;
   logic [7:0]           rsp_red;
   logic [7:0]           rsp_green;
   logic [7:0]           rsp_blue;
   logic                 rsp_frame_end;
   logic                 csr_write      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [DIM_W-1:0]     csr_data       = '0;

   fire_cell_scoreboard sb;
   bit          tx_idle       = 1'b1;   // sender may insert gaps
   bit          rx_idle       = 1'b1;   // receiver may stall
   bit          long_hold_req = 1'b0;   // ask the receiver for one long hold-off
   int unsigned cycles_seen   = 0;

   fire_effect_cell_engine u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rand_value (req_rand_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_led_index  (rsp_led_index),
      .rsp_heat       (rsp_heat),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_frame_end  (rsp_frame_end),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // Watchdog: end the run if the block hangs or loses pixels.
   initial begin : watchdog
      while (cycles_seen < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_seen++;
      end
      $display("tb: failure");
      $finish;
   end

   // Result side: stall in short random bursts, or hold off for one long stretch on request.
   initial begin : rsp_backpressure
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            long_hold_req = 1'b0;
         end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 3)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end
      end
   end

   // Check every pixel taken at a rising edge against the oldest prediction.
   always @(posedge clock) begin
      pixel_type seen;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         seen.led_index = rsp_led_index;
         seen.heat      = rsp_heat;
         seen.red       = rsp_red;
         seen.green     = rsp_green;
         seen.blue      = rsp_blue;
         seen.frame_end = rsp_frame_end;
         sb.check_pixel(seen);
      end
   end

   // Offer one nibble, optionally after a gap; hold it until taken, then predict.
   task automatic send_item(input logic [NIB_W-1:0] nibble);
      if (tx_idle && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_rand_value <= NIB_W'($urandom_range(0, 15));
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_rand_value <= nibble;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_step(nibble);
   endtask

   // Write one register; only called while the block is idle.
   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] d);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      sb.write_reg(idx, d);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Drop valid, drain every owed pixel, then let trailing seed items finish.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned items_sent;
      int unsigned kind;
      int unsigned cells;
      int unsigned burst;
      sb = new();
      items_sent = 0;

      // Hold reset, then wait out the clearing pass of the heat store.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (req_stall !== 1'b0);

      // Two rows in use, reached through values below the minimum.
      set_reg(CSR_COLS, 6'd1);
      set_reg(CSR_ROWS, 6'd0);
      send_item(4'd15);
      send_item(4'd0);
      send_item(4'd8);
      send_item(4'd9);
      // Hot threshold pair: 9 seeds hot, 8 seeds cold.
      send_item(4'd9);
      send_item(4'd8);
      send_item(4'd0);
      send_item(4'd15);
      settle();

      // Unknown indexes mid-frame: the frame must carry on where it was.
      send_item(4'd9);
      settle();
      set_reg(CSR_SPARE_A, 6'd63);
      set_reg(CSR_SPARE_B, 6'd5);
      send_item(4'd12);
      send_item(4'd3);
      send_item(4'd7);
      settle();

      // Restart in the update phase, with a value above the maximum.
      send_item(4'd15);
      send_item(4'd15);
      settle();
      set_reg(CSR_COLS, 6'd63);
      send_item(4'd15);
      send_item(4'd15);
      send_item(4'd15);
      settle();
      set_reg(CSR_ROWS, 6'd33);
      set_reg(CSR_COLS, 6'd3);
      send_item(4'd15);
      send_item(4'd14);
      send_item(4'd13);
      send_item(4'd0);
      send_item(4'd0);
      send_item(4'd0);
      settle();

      // Long hold-off on the result side while items keep coming; fill the block.
      set_reg(CSR_COLS, 6'd8);
      set_reg(CSR_ROWS, 6'd4);
      long_hold_req = 1'b1;
      repeat (32) send_item(NIB_W'($urandom_range(0, 15)));
      settle();

      // Random phases: mostly whole frames on small matrices, some wide or tall ones,
      // some left unfinished and picked up again or cut short by a write.
      while (items_sent < RANDOM_ITEMS) begin
         tx_idle = (items_sent + TAIL_ITEMS < RANDOM_ITEMS) && ($urandom_range(0, 3) != 0);
         rx_idle = (items_sent + TAIL_ITEMS < RANDOM_ITEMS) && ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 9);
         case (kind)
            0: begin
               set_reg(CSR_COLS, ($urandom_range(0, 1) == 1) ? 6'd32 :
                                 DIM_W'($urandom_range(33, 63)));
               set_reg(CSR_ROWS, DIM_W'($urandom_range(2, 4)));
            end
            1: begin
               set_reg(CSR_ROWS, DIM_W'($urandom_range(32, 63)));
               set_reg(CSR_COLS, DIM_W'($urandom_range(2, 3)));
            end
            2: begin
               set_reg(CSR_COLS, 6'd32);
               set_reg(CSR_ROWS, 6'd32);
            end
            3: begin
               // keep the running frame
            end
            4: begin
               set_reg(($urandom_range(0, 1) == 1) ? CSR_SPARE_A : CSR_SPARE_B,
                       DIM_W'($urandom));
            end
            default: begin
               set_reg(CSR_COLS, DIM_W'($urandom_range(0, 6)));
               set_reg(CSR_ROWS, DIM_W'($urandom_range(0, 6)));
            end
         endcase
         cells = sb.n_cols * sb.n_rows;
         if (kind == 3 || kind == 4) begin
            burst = $urandom_range(4, 30);
         end else if (cells > 48) begin
            burst = $urandom_range(48, 100);
         end else begin
            burst = cells * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) burst = burst + $urandom_range(1, cells - 1);
         end
         repeat (burst) send_item(NIB_W'($urandom_range(0, 15)));
         items_sent = items_sent + burst;
         settle();
      end

      if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
